/* design/sfbb_pkg.sv */
`timescale 1ns / 1ps

package sfbb_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOUR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM_ENABLE  = 3'd3;

	localparam int CFG_DATA_W = 24;

	// Register reset values.
	localparam logic [23:0] KEY_COLOUR_RESET = 24'hFF00FF;
	localparam logic [8:0]  FRAME_DIM_RESET  = 9'd256;

	// One pixel request.
	typedef struct packed {
		logic [23:0] pixel;
		logic [7:0]  frame_col;
		logic [7:0]  frame_row;
	} pix_req_t;

	// One bounding box result.
	typedef struct packed {
		logic [7:0] tag_col;
		logic [7:0] tag_row;
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] top;
		logic [7:0] bottom;
		logic [6:0] centre_x;
		logic [6:0] centre_y;
		logic [8:0] trim_width;
		logic [8:0] trim_height;
	} box_req_t;

	// Status from the bounds tracker for the pixel now being processed.
	typedef struct packed {
		logic last_pixel;
		logic seen;
	} track_stat_t;

endpackage

/* design/sprite_frame_bounding_box.sv */
`timescale 1ns / 1ps

// Foreground bounding box of sprite frames. Pixels of one frame arrive in raster
// order, one request per cycle, and each is compared with the key colour; every
// pixel that differs widens the box of content columns and rows. On the frame's
// last pixel one result request is issued with left, right, top and bottom, the
// halved spans as centre and the trimmed width and height, and the tracker starts
// afresh for the next frame. A blank frame reports its last column and row as
// the box; with trimming off the whole frame is reported. A pixel request waits
// in the input register and is then folded into the bounds, so the block
// sustains one pixel per clock, limited only by back-pressure on the result
// side: an occupied result register stalls only the last pixel of a frame. A
// frame width or height of zero acts as one, and values above MAX_FRAME_DIM are
// clamped to it. Any configuration write, whatever its index, restarts the frame
// in progress; the configuration port is always ready, and it is to be written
// only while no pixel request is in flight.
module sprite_frame_bounding_box #(
	parameter int MAX_FRAME_DIM = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  sfbb_pkg::pix_req_t                 pix,
	output logic                               box_valid,
	input  logic                               box_stall,
	output sfbb_pkg::box_req_t                 box,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sfbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Counter width, width holding the clamped dimension, width for the
	// comparison against the 9-bit register, and width of the span arithmetic.
	localparam int CW = $clog2(MAX_FRAME_DIM);
	localparam int EW = CW + 1;
	localparam int XW = (EW > 9) ? EW : 9;
	localparam int SW = (CW > 9) ? CW : 9;

	// Configuration registers.
	logic [23:0] key_q;
	logic [8:0]  width_q;
	logic [8:0]  height_q;
	logic        trim_q;
	logic        cfg_write;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= sfbb_pkg::KEY_COLOUR_RESET;
			width_q  <= sfbb_pkg::FRAME_DIM_RESET;
			height_q <= sfbb_pkg::FRAME_DIM_RESET;
			trim_q   <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				sfbb_pkg::REG_KEY_COLOUR:   key_q    <= cfg_data[23:0];
				sfbb_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data[8:0];
				sfbb_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data[8:0];
				sfbb_pkg::REG_TRIM_ENABLE:  trim_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Effective dimensions: zero acts as one, anything above the maximum is
	// clamped. The last column and row index then always fit the counters.
	logic [XW-1:0] width_x;
	logic [XW-1:0] height_x;
	logic [XW-1:0] width_eff;
	logic [XW-1:0] height_eff;
	logic [XW-1:0] dim_max;
	logic [CW-1:0] width_m1;
	logic [CW-1:0] height_m1;

	assign width_x  = XW'(width_q);
	assign height_x = XW'(height_q);
	assign dim_max  = XW'(MAX_FRAME_DIM);

	always_comb begin
		if (width_x == '0) width_eff = XW'(1);
		else if (width_x > dim_max) width_eff = dim_max;
		else width_eff = width_x;
		if (height_x == '0) height_eff = XW'(1);
		else if (height_x > dim_max) height_eff = dim_max;
		else height_eff = height_x;
	end

	assign width_m1  = CW'(width_eff - XW'(1));
	assign height_m1 = CW'(height_eff - XW'(1));

	// Input register: holds one pixel request until it is folded into the
	// bounds. Only a frame's last pixel waits, and only for the result slot.
	logic               valid_s1;
	sfbb_pkg::pix_req_t pix_s1;
	logic               advance;
	logic               out_free;
	logic               pix_accept;
	sfbb_pkg::track_stat_t stat;

	assign out_free   = !box_valid || !box_stall;
	assign advance    = valid_s1 && (!stat.last_pixel || out_free);
	assign pix_stall  = valid_s1 && !advance;
	assign pix_accept = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pix_s1 <= pix;
		end
	end

	// Position counters and running bounds, including the pixel now in stage 1.
	logic [CW-1:0] min_col_nxt;
	logic [CW-1:0] max_col_nxt;
	logic [CW-1:0] min_row_nxt;
	logic [CW-1:0] max_row_nxt;

	sfbb_bounds #(
		.CW(CW)
	) u_bounds (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_write),
		.step       (advance),
		.hit        (pix_s1.pixel != key_q),
		.width_m1   (width_m1),
		.height_m1  (height_m1),
		.stat       (stat),
		.min_col_nxt(min_col_nxt),
		.max_col_nxt(max_col_nxt),
		.min_row_nxt(min_row_nxt),
		.max_row_nxt(max_row_nxt)
	);

	// Box selection: full frame when trimming is off, the last column and row
	// for a blank frame, the tracked bounds otherwise.
	logic [CW-1:0] box_l;
	logic [CW-1:0] box_r;
	logic [CW-1:0] box_t;
	logic [CW-1:0] box_b;
	logic [SW-1:0] l_ext;
	logic [SW-1:0] r_ext;
	logic [SW-1:0] t_ext;
	logic [SW-1:0] b_ext;
	logic [SW-1:0] span_x;
	logic [SW-1:0] span_y;
	sfbb_pkg::box_req_t box_d;

	always_comb begin
		if (!trim_q) begin
			box_l = '0;
			box_r = width_m1;
			box_t = '0;
			box_b = height_m1;
		end else if (!stat.seen) begin
			box_l = width_m1;
			box_r = width_m1;
			box_t = height_m1;
			box_b = height_m1;
		end else begin
			box_l = min_col_nxt;
			box_r = max_col_nxt;
			box_t = min_row_nxt;
			box_b = max_row_nxt;
		end
	end

	assign l_ext  = SW'(box_l);
	assign r_ext  = SW'(box_r);
	assign t_ext  = SW'(box_t);
	assign b_ext  = SW'(box_b);
	assign span_x = r_ext - l_ext;
	assign span_y = b_ext - t_ext;

	always_comb begin
		box_d.tag_col     = pix_s1.frame_col;
		box_d.tag_row     = pix_s1.frame_row;
		box_d.left        = l_ext[7:0];
		box_d.right       = r_ext[7:0];
		box_d.top         = t_ext[7:0];
		box_d.bottom      = b_ext[7:0];
		box_d.centre_x    = span_x[7:1];
		box_d.centre_y    = span_y[7:1];
		box_d.trim_width  = span_x[8:0] + 9'd1;
		box_d.trim_height = span_y[8:0] + 9'd1;
	end

	// Result register: loaded on a frame's last pixel, emptied when taken.
	logic load_box;

	assign load_box = advance && stat.last_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid <= 1'b0;
		end else if (load_box) begin
			box_valid <= 1'b1;
		end else if (!box_stall) begin
			box_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_box) begin
			box <= box_d;
		end
	end

	// A pixel held back in the input register is still there, unchanged,
	// in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(pix_s1)))
		else $error("held pixel request lost or changed");

	// A frame's last pixel always yields a result request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && stat.last_pixel) |=> box_valid)
		else $error("frame end produced no result");

	// Back-pressure is only applied while a pixel waits in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !pix_stall)
		else $error("stall raised with an empty input register");

endmodule

/* design/sfbb_bounds.sv */
`timescale 1ns / 1ps

// Raster position counters and running content bounds of the current frame.
module sfbb_bounds #(
	parameter int CW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic                 step,
	input  logic                 hit,
	input  logic [CW-1:0]        width_m1,
	input  logic [CW-1:0]        height_m1,
	output sfbb_pkg::track_stat_t stat,
	output logic [CW-1:0]        min_col_nxt,
	output logic [CW-1:0]        max_col_nxt,
	output logic [CW-1:0]        min_row_nxt,
	output logic [CW-1:0]        max_row_nxt
);

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] min_col_q;
	logic [CW-1:0] max_col_q;
	logic [CW-1:0] min_row_q;
	logic [CW-1:0] max_row_q;
	logic          seen_q;
	logic          last_col;
	logic          last_row;

	assign last_col = col_q >= width_m1;
	assign last_row = row_q >= height_m1;

	always_comb begin
		min_col_nxt = min_col_q;
		max_col_nxt = max_col_q;
		min_row_nxt = min_row_q;
		max_row_nxt = max_row_q;
		if (hit) begin
			if (!seen_q) begin
				min_col_nxt = col_q;
				max_col_nxt = col_q;
				min_row_nxt = row_q;
				max_row_nxt = row_q;
			end else begin
				if (col_q < min_col_q) min_col_nxt = col_q;
				if (col_q > max_col_q) max_col_nxt = col_q;
				if (row_q < min_row_q) min_row_nxt = row_q;
				if (row_q > max_row_q) max_row_nxt = row_q;
			end
		end
	end

	assign stat.last_pixel = last_col && last_row;
	assign stat.seen       = seen_q || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '1;
			max_col_q <= '0;
			min_row_q <= '1;
			max_row_q <= '0;
			seen_q    <= 1'b0;
		end else if (restart || (step && stat.last_pixel)) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '1;
			max_col_q <= '0;
			min_row_q <= '1;
			max_row_q <= '0;
			seen_q    <= 1'b0;
		end else if (step) begin
			min_col_q <= min_col_nxt;
			max_col_q <= max_col_nxt;
			min_row_q <= min_row_nxt;
			max_row_q <= max_row_nxt;
			seen_q    <= stat.seen;
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule
